// ===== hw/rtl/spmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmf_pkg
// shared sizes and the decision record for the strict priority ring queues
// ----------------------------------------------------------------------------
package spmf_pkg;

    localparam int LEVELS      = 4;
    localparam int QUEUE_DEPTH = 64;
    localparam int HANDLE_BITS = 16;

    localparam int SLOT_COUNT = LEVELS * QUEUE_DEPTH;
    localparam int PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int ADDR_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int PRIO_W     = 2;

    typedef enum logic
    {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } op_t;

    // what the pointer logic decides for one accepted item
    typedef struct packed
    {
        logic              ok;
        logic              wr_en;
        logic              rd_en;
        logic [PRIO_W-1:0] level;
        logic [ADDR_W-1:0] addr;
    } spmf_dec_t;

endpackage

// ===== hw/rtl/strict_priority_multi_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_priority_multi_fifo
// one ring queue per priority level in a shared slot ram, strict priority pop
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     in_valid / in_ready  op, priority_req, handle
//  output    out_valid/out_ready  ok, out_handle, out_level
//
//  one item per cycle unless a waiting result stalls in_ready; its result
//  comes the cycle after the transfer, once the single-port ram read returns.
//  pointers move at input transfer, so the next item sees them at once.
//  a waiting result holds the pipe: in_ready follows out_ready then.
//  reset clears all ring pointers; the slot ram needs no clearing.
// ----------------------------------------------------------------------------
module strict_priority_multi_fifo (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             op,
    input  logic [spmf_pkg::PRIO_W-1:0]      priority_req,
    input  logic [spmf_pkg::HANDLE_BITS-1:0] handle,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             ok,
    output logic [spmf_pkg::HANDLE_BITS-1:0] out_handle,
    output logic [spmf_pkg::PRIO_W-1:0]      out_level
);
    import spmf_pkg::*;

    logic                   accept;
    spmf_dec_t              dec;
    logic [HANDLE_BITS-1:0] rdata;

    logic              res_valid_reg;
    logic              res_ok_reg;
    logic              res_deq_reg;
    logic [PRIO_W-1:0] res_level_reg;

    assign in_ready = !res_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    spmf_ptr_ctrl u_ptr (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .op           (op),
        .priority_req (priority_req),
        .dec          (dec)
    );

    spmf_slot_ram #(
        .DEPTH  (SLOT_COUNT),
        .WIDTH  (HANDLE_BITS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (accept && dec.wr_en),
        .re    (accept && dec.rd_en),
        .addr  (dec.addr),
        .wdata (handle),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            res_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_ok_reg    <= dec.ok;
            res_deq_reg   <= dec.rd_en;
            res_level_reg <= dec.level;
        end
    end

    assign out_valid  = res_valid_reg;
    assign ok         = res_ok_reg;
    assign out_handle = res_deq_reg ? rdata : '0;
    assign out_level  = res_level_reg;

`ifndef ASSERT_OFF
    a_deq_implies_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && res_deq_reg) |-> res_ok_reg)
        else $error("ram read issued for a dequeue that found nothing");

    a_level_zero_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !res_deq_reg) |-> (out_level == '0 && out_handle == '0))
        else $error("level or handle set on a result without a dequeue");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("transfer without a result the next cycle");
`endif

endmodule

// ===== hw/rtl/spmf_slot_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmf_slot_ram
// single-port synchronous ram, registered read, read data held
// ----------------------------------------------------------------------------
module spmf_slot_ram #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/spmf_ptr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmf_ptr_ctrl
// per-level head and tail pointers, full and empty flags, priority select
// ----------------------------------------------------------------------------
module spmf_ptr_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic                       op,
    input  logic [spmf_pkg::PRIO_W-1:0] priority_req,
    output spmf_pkg::spmf_dec_t        dec
);
    import spmf_pkg::*;

    logic [PTR_W-1:0] wp_reg [LEVELS];
    logic [PTR_W-1:0] rp_reg [LEVELS];
    logic [LEVELS-1:0] empty;
    logic [LEVELS-1:0] full;

    logic              enq_in_range;
    logic [PRIO_W-1:0] enq_lvl;
    logic              any_valid;
    logic [PRIO_W-1:0] deq_lvl;
    logic [PTR_W-1:0]  wp_sel;
    logic [PTR_W-1:0]  rp_sel;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [PRIO_W-1:0] l,
                                                    input logic [PTR_W-1:0]  p);
        return ADDR_W'(ADDR_W'(l) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(p);
    endfunction

    always_comb
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            empty[i] = (rp_reg[i] == wp_reg[i]);
            full[i]  = (bump(wp_reg[i]) == rp_reg[i]);
        end
    end

    // highest non-empty level wins
    always_comb
    begin
        any_valid = 1'b0;
        deq_lvl   = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (!empty[i])
            begin
                any_valid = 1'b1;
                deq_lvl   = PRIO_W'(i);
            end
        end
    end

    assign enq_in_range = (32'(priority_req) < LEVELS);
    assign enq_lvl      = priority_req;

    always_comb
    begin
        wp_sel = '0;
        rp_sel = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (enq_lvl == PRIO_W'(i))
            begin
                wp_sel = wp_reg[i];
            end
            if (deq_lvl == PRIO_W'(i))
            begin
                rp_sel = rp_reg[i];
            end
        end
    end

    always_comb
    begin
        dec = '0;
        case (op_t'(op))
            OP_ENQUEUE:
            begin
                dec.wr_en = enq_in_range && !full[enq_lvl];
                dec.ok    = dec.wr_en;
                dec.addr  = slot_addr(enq_lvl, wp_sel);
            end
            OP_DEQUEUE:
            begin
                dec.rd_en = any_valid;
                dec.ok    = any_valid;
                dec.level = any_valid ? deq_lvl : '0;
                dec.addr  = slot_addr(deq_lvl, rp_sel);
            end
            default:
            begin
                dec = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                wp_reg[i] <= '0;
                rp_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                if (dec.wr_en && enq_lvl == PRIO_W'(i))
                begin
                    wp_reg[i] <= bump(wp_reg[i]);
                end
                if (dec.rd_en && deq_lvl == PRIO_W'(i))
                begin
                    rp_reg[i] <= bump(rp_reg[i]);
                end
            end
        end
    end

`ifndef ASSERT_OFF
    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(dec.wr_en && dec.rd_en))
        else $error("ring write and read decided for one item");

    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (full & empty) == '0)
        else $error("a ring is both full and empty");

    a_deq_miss_all_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_DEQUEUE && !dec.ok) |-> (empty == {LEVELS{1'b1}}))
        else $error("dequeue missed while a ring holds entries");

    a_enq_fills_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && dec.wr_en) |=> !empty[$past(enq_lvl)])
        else $error("ring still empty after a stored enqueue");
`endif

endmodule
